### design/nfa_bm_pkg.sv
// ----------------------------------------------------------------------------
// nfa_bm_pkg
// shared codes and types for the bit-set nfa matcher
// ----------------------------------------------------------------------------
package nfa_bm_pkg;

  // input operation codes
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_START  = 2'd1,
    OP_SYMBOL = 2'd2
  } op_t;

  // configuration register indexes
  localparam logic CFG_START_MASK  = 1'b0;
  localparam logic CFG_ACCEPT_MASK = 1'b1;

  localparam int CFG_W = 16;

  localparam logic [CFG_W-1:0] START_MASK_RST  = 16'h0001;
  localparam logic [CFG_W-1:0] ACCEPT_MASK_RST = 16'h0000;

  // symbol code that holds the epsilon edges ('.')
  localparam logic [7:0] EPS_CODE = 8'd46;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_ACC,
    ST_EPS_RD,
    ST_EPS_ACC,
    ST_DONE
  } state_t;

endpackage

### design/nfa_bm_table.sv
// ----------------------------------------------------------------------------
// nfa_bm_table
// transition table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module nfa_bm_table #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### design/nfa_bitset_matcher_unit.sv
// ----------------------------------------------------------------------------
// nfa_bitset_matcher_unit
// nfa simulation over a symbol stream with the active set kept as a bit
// vector; rows of the transition table are or-ed in one at a time
// ----------------------------------------------------------------------------
//
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------------
// in_      | input     | in_valid / in_stall  | operation, state_index, symbol,
//          |           |                      | target_set
// out_     | output    | out_valid / out_stall| active_set, matched
// cfg_     | input     | cfg_wr_en            | cfg_index, cfg_wr_data
//
// work: a table write or an unused code goes straight to the result stage; a
//   start visits the states of the epsilon closure, and a symbol first the
//   states active before it, then the states of the closure. the single
//   table read port serves one visited state at a time: each one is read,
//   then its row is or-ed into the working set (ROW_RD then ROW_ACC, or
//   EPS_RD then EPS_ACC)
// reset: rst_n clears control state, then a clearing pass writes zero to
//   every table entry, NUM_STATES << SYMBOL_BITS entries (4096 by default);
//   in_stall stays high meanwhile, configuration writes are taken as ever
// stalls: one transaction is worked on at a time; a finished result sits in
//   the output register while the next transaction is accepted
// ----------------------------------------------------------------------------
module nfa_bitset_matcher_unit #(
  parameter int NUM_STATES  = 16,
  parameter int SYMBOL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,

  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_state_index,
  input  logic [7:0]  in_symbol,
  input  logic [15:0] in_target_set,

  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_active_set,
  output logic        out_matched,

  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wr_data
);

  // state index width and table geometry
  localparam int SW     = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int DEPTH  = NUM_STATES << SYMBOL_BITS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [SYMBOL_BITS-1:0] EPS_SYM = nfa_bm_pkg::EPS_CODE[SYMBOL_BITS-1:0];

  // lowest set bit of a state set
  function automatic logic [SW-1:0] low_idx(input logic [NUM_STATES-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int i = NUM_STATES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = SW'(i);
      end
    end
    return r;
  endfunction

  nfa_bm_pkg::state_t state_r, state_nxt;

  logic [nfa_bm_pkg::CFG_W-1:0] start_mask_r;
  logic [nfa_bm_pkg::CFG_W-1:0] accept_mask_r;

  logic [NUM_STATES-1:0]  cur_r, cur_nxt;      // committed active set
  logic [NUM_STATES-1:0]  work_r, work_nxt;    // row union / closure set
  logic [NUM_STATES-1:0]  pend_r, pend_nxt;    // states still to visit
  logic [SYMBOL_BITS-1:0] sym_r, sym_nxt;
  logic [ADDR_W-1:0]      clr_cnt_r, clr_cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_active_set_r, out_active_set_nxt;
  logic        out_matched_r, out_matched_nxt;

  // table ports
  logic                  tbl_wr_en;
  logic [ADDR_W-1:0]     tbl_wr_addr;
  logic [NUM_STATES-1:0] tbl_wr_data;
  logic [ADDR_W-1:0]     tbl_rd_addr;
  logic [NUM_STATES-1:0] tbl_rd_data;

  logic                  in_accept;
  logic [SW-1:0]         pend_idx;
  logic [NUM_STATES-1:0] pend_clr;
  logic                  src_ok;

  nfa_bm_table #(
    .DATA_W (NUM_STATES),
    .DEPTH  (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  assign in_stall  = (state_r != nfa_bm_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign pend_idx = low_idx(pend_r);
  assign pend_clr = pend_r & ~(NUM_STATES'(1) << pend_idx);
  assign src_ok   = (32'(in_state_index) < 32'(NUM_STATES));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mask_r  <= nfa_bm_pkg::START_MASK_RST;
      accept_mask_r <= nfa_bm_pkg::ACCEPT_MASK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nfa_bm_pkg::CFG_START_MASK:  start_mask_r  <= cfg_wr_data;
        nfa_bm_pkg::CFG_ACCEPT_MASK: accept_mask_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfa_bm_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    work_r           <= work_nxt;
    pend_r           <= pend_nxt;
    sym_r            <= sym_nxt;
    out_active_set_r <= out_active_set_nxt;
    out_matched_r    <= out_matched_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt          = state_r;
    clr_cnt_nxt        = clr_cnt_r;
    cur_nxt            = cur_r;
    work_nxt           = work_r;
    pend_nxt           = pend_r;
    sym_nxt            = sym_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_active_set_nxt = out_active_set_r;
    out_matched_nxt    = out_matched_r;
    tbl_wr_en          = 1'b0;
    tbl_wr_addr        = {SW'(in_state_index), in_symbol[SYMBOL_BITS-1:0]};
    tbl_wr_data        = NUM_STATES'(in_target_set);
    tbl_rd_addr        = {pend_idx, sym_r};

    case (state_r)
      // zero the table after reset
      nfa_bm_pkg::ST_CLEAR: begin
        tbl_wr_en   = 1'b1;
        tbl_wr_addr = clr_cnt_r;
        tbl_wr_data = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = nfa_bm_pkg::ST_IDLE;
        end
      end

      nfa_bm_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_operation)
            nfa_bm_pkg::OP_WRITE: begin
              tbl_wr_en = src_ok;
              state_nxt = nfa_bm_pkg::ST_DONE;
            end
            nfa_bm_pkg::OP_START: begin
              work_nxt  = NUM_STATES'(start_mask_r);
              pend_nxt  = NUM_STATES'(start_mask_r);
              state_nxt = nfa_bm_pkg::ST_EPS_RD;
            end
            nfa_bm_pkg::OP_SYMBOL: begin
              work_nxt  = '0;
              pend_nxt  = cur_r;
              sym_nxt   = in_symbol[SYMBOL_BITS-1:0];
              state_nxt = nfa_bm_pkg::ST_ROW_RD;
            end
            default: begin
              state_nxt = nfa_bm_pkg::ST_DONE;
            end
          endcase
        end
      end

      // union of the symbol rows of the active states
      nfa_bm_pkg::ST_ROW_RD: begin
        if (pend_r == '0) begin
          pend_nxt  = work_r;
          state_nxt = nfa_bm_pkg::ST_EPS_RD;
        end else begin
          pend_nxt  = pend_clr;
          state_nxt = nfa_bm_pkg::ST_ROW_ACC;
        end
      end

      nfa_bm_pkg::ST_ROW_ACC: begin
        work_nxt  = work_r | tbl_rd_data;
        state_nxt = nfa_bm_pkg::ST_ROW_RD;
      end

      // epsilon closure, each state visited once
      nfa_bm_pkg::ST_EPS_RD: begin
        tbl_rd_addr = {pend_idx, EPS_SYM};
        if (pend_r == '0) begin
          cur_nxt   = work_r;
          state_nxt = nfa_bm_pkg::ST_DONE;
        end else begin
          pend_nxt  = pend_clr;
          state_nxt = nfa_bm_pkg::ST_EPS_ACC;
        end
      end

      nfa_bm_pkg::ST_EPS_ACC: begin
        // newly reached states join the work list
        pend_nxt  = pend_r | (tbl_rd_data & ~work_r);
        work_nxt  = work_r | tbl_rd_data;
        state_nxt = nfa_bm_pkg::ST_EPS_RD;
      end

      // hand the result to the output register once it is free
      nfa_bm_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_active_set_nxt = 16'(cur_r);
          out_matched_nxt    = |(cur_r & NUM_STATES'(accept_mask_r));
          state_nxt          = nfa_bm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = nfa_bm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_active_set = out_active_set_r;
  assign out_matched    = out_matched_r;

endmodule

### test/nfa_bitset_matcher_unit_tb.sv
// ----------------------------------------------------------------------------
// nfa_bitset_matcher_unit_tb
// self-checking bench for the bit-set nfa matcher: a directed table followed
// by random table writes, starts and symbol streams under several mask
// settings, with random idling on both channels and one long output hold-off;
// every result is compared with an in-bench model of the automaton
// ----------------------------------------------------------------------------
module nfa_bitset_matcher_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ST      = 16;
  localparam int N_SYM     = 256;
  localparam int ROWS      = N_ST * N_SYM;
  localparam int PHASE_LEN = 225;
  localparam int HOLD_LEN  = 300;
  localparam int TAIL_LEN  = 80;
  // clearing pass plus ~900 transactions at worst-case latency and stalls
  localparam int CYCLE_LIMIT = 500000;

  // operation code the block does not define
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] active_set;
    logic        matched;
  } nfa_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [7:0]  sym;
    logic [15:0] tgt;
    logic        known;
    logic [15:0] exp_set;
    logic        exp_match;
  } nfa_stim_t;

  localparam int N_DIR = 23;

  // directed transactions; expected values are typed in only where obvious
  localparam nfa_stim_t DIRECTED [0:N_DIR-1] = '{
    // symbol before any start: nothing active
    '{nfa_bm_pkg::OP_SYMBOL, 4'h0, 8'h61, 16'h0000, 1'b1, 16'h0000, 1'b0},
    // undefined code with every payload bit set: just reports
    '{OP_UNUSED, 4'hF, 8'hFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
    // start from reset mask with an empty table
    '{nfa_bm_pkg::OP_START,  4'h0, 8'h00, 16'h0000, 1'b1, 16'h0001, 1'b0},
    // table write reports the active set unchanged
    '{nfa_bm_pkg::OP_WRITE,  4'h0, 8'h61, 16'h0002, 1'b1, 16'h0001, 1'b0},
    '{nfa_bm_pkg::OP_WRITE,  4'h1, nfa_bm_pkg::EPS_CODE, 16'h0004, 1'b0, 16'h0000, 1'b0},
    '{nfa_bm_pkg::OP_WRITE,  4'h2, nfa_bm_pkg::EPS_CODE, 16'h0008, 1'b0, 16'h0000, 1'b0},
    // 'a' then a two-step epsilon chain
    '{nfa_bm_pkg::OP_SYMBOL, 4'h0, 8'h61, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{nfa_bm_pkg::OP_WRITE,  4'h3, 8'h62, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    // symbol with stray index and target bits, which are ignored
    '{nfa_bm_pkg::OP_SYMBOL, 4'hF, 8'h62, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    // highest state, highest symbol code
    '{nfa_bm_pkg::OP_WRITE,  4'hF, 8'hFF, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{nfa_bm_pkg::OP_SYMBOL, 4'h0, 8'hFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // a literal '.' input follows the epsilon rows
    '{nfa_bm_pkg::OP_SYMBOL, 4'h0, nfa_bm_pkg::EPS_CODE, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{nfa_bm_pkg::OP_WRITE,  4'h0, nfa_bm_pkg::EPS_CODE, 16'h0002, 1'b0, 16'h0000, 1'b0},
    '{nfa_bm_pkg::OP_WRITE,  4'h3, nfa_bm_pkg::EPS_CODE, 16'h0010, 1'b0, 16'h0000, 1'b0},
    '{nfa_bm_pkg::OP_WRITE,  4'h4, nfa_bm_pkg::EPS_CODE, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{nfa_bm_pkg::OP_WRITE,  4'hF, nfa_bm_pkg::EPS_CODE, 16'h0020, 1'b0, 16'h0000, 1'b0},
    // start now closes over a long epsilon chain
    '{nfa_bm_pkg::OP_START,  4'h0, 8'h00, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{nfa_bm_pkg::OP_SYMBOL, 4'h0, 8'h00, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{OP_UNUSED, 4'h0, 8'h00, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{nfa_bm_pkg::OP_START,  4'h0, 8'h00, 16'h0000, 1'b0, 16'h0000, 1'b0},
    // overwrite an edge with the empty set
    '{nfa_bm_pkg::OP_WRITE,  4'h0, 8'h61, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{nfa_bm_pkg::OP_SYMBOL, 4'h0, 8'h61, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{nfa_bm_pkg::OP_WRITE,  4'hF, 8'h00, 16'hFFFF, 1'b0, 16'h0000, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [3:0]  in_state_index;
  logic [7:0]  in_symbol;
  logic [15:0] in_target_set;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_active_set;
  logic        out_matched;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [15:0] cfg_wr_data;

  nfa_bitset_matcher_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_state_index (in_state_index),
    .in_symbol      (in_symbol),
    .in_target_set  (in_target_set),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_active_set (out_active_set),
    .out_matched    (out_matched),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data)
  );

  // model of the automaton: transition rows, active set and both masks
  logic [15:0] nfa_rows [0:ROWS-1];
  logic [15:0] live_set;
  logic [15:0] start_set_q;
  logic [15:0] accept_set_q;

  nfa_result_t pending_q [$];

  int err_cnt;
  int cycle_cnt;
  int snd_idle_pct;
  int rcv_idle_pct;
  bit pressure_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // model
  // ---------------------------------------------------------------------------

  // union of the rows of every state in the set for one symbol
  function automatic logic [15:0] gather_rows(input logic [15:0] set, input logic [7:0] sym);
    logic [15:0] acc;
    acc = '0;
    for (int s = 0; s < N_ST; s++) begin
      if (set[s]) acc |= nfa_rows[s * N_SYM + sym];
    end
    return acc;
  endfunction

  // the set only grows, so N_ST passes always reach the fixed point
  function automatic logic [15:0] eps_close(input logic [15:0] set);
    logic [15:0] grown;
    grown = set;
    for (int p = 0; p < N_ST; p++) begin
      grown = grown | gather_rows(grown, nfa_bm_pkg::EPS_CODE);
    end
    return grown;
  endfunction

  function automatic nfa_result_t advance_matcher(input logic [1:0] op, input logic [3:0] idx,
                                                  input logic [7:0] sym,
                                                  input logic [15:0] tgt);
    nfa_result_t res;
    case (op)
      nfa_bm_pkg::OP_WRITE: begin
        if (int'(idx) < N_ST) nfa_rows[int'(idx) * N_SYM + sym] = tgt;
      end
      nfa_bm_pkg::OP_START:  live_set = eps_close(start_set_q);
      nfa_bm_pkg::OP_SYMBOL: live_set = eps_close(gather_rows(live_set, sym));
      default: ;
    endcase
    res.active_set = live_set;
    res.matched    = |(live_set & accept_set_q);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one or two random states, occasionally none
  function automatic logic [15:0] sparse_set();
    logic [15:0] s;
    s = 16'h0001 << $urandom_range(0, N_ST - 1);
    if ($urandom_range(0, 1) == 1) s |= 16'h0001 << $urandom_range(0, N_ST - 1);
    if ($urandom_range(0, 9) == 0) s = '0;
    return s;
  endfunction

  // mostly a small alphabet so streams hit the rows that were written
  function automatic logic [7:0] pick_symbol();
    logic [7:0] c;
    if ($urandom_range(0, 99) < 80) begin
      case ($urandom_range(0, 3))
        0:       c = 8'h61;
        1:       c = 8'h62;
        2:       c = 8'h63;
        default: c = nfa_bm_pkg::EPS_CODE;
      endcase
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", msg);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [1:0] op, input logic [3:0] idx, input logic [7:0] sym,
                           input logic [15:0] tgt, input logic known,
                           input nfa_result_t typed);
    nfa_result_t res;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_operation   = op;
    in_state_index = idx;
    in_symbol      = sym;
    in_target_set  = tgt;
    do @(posedge clk); while (in_stall);
    // accepted at this edge: the model advances in transaction order
    res = advance_matcher(op, idx, sym, tgt);
    if (known) res = typed;
    pending_q = {pending_q, res};
    @(negedge clk);
  endtask

  // block is idle once every expected result has come out
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] val);
    cfg_wr_en   = 1'b1;
    cfg_index   = idx;
    cfg_wr_data = val;
    @(posedge clk);
    if (idx == nfa_bm_pkg::CFG_START_MASK) start_set_q = val;
    else accept_set_q = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall, or one long hold-off when asked for
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_req) begin
        // hold the output so the block fills and stalls its input
        out_stall = 1'b1;
        for (int h = 0; h < HOLD_LEN; h++) @(negedge clk);
        pressure_req = 1'b0;
      end
      out_stall = ($urandom_range(0, 99) < rcv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: oldest expectation first
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    nfa_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        flag_error($sformatf("unexpected result set %h matched %b",
                             out_active_set, out_matched));
      end else begin
        want = pending_q.pop_front();
        if (out_active_set !== want.active_set)
          flag_error($sformatf("active_set expected %h got %h",
                               want.active_set, out_active_set));
        if (out_matched !== want.matched)
          flag_error($sformatf("matched expected %b got %b (set %h)",
                               want.matched, out_matched, want.active_set));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [1:0]  r_op;
    logic [3:0]  r_idx;
    logic [7:0]  r_sym;
    logic [15:0] r_tgt;
    logic [15:0] st_val;
    logic [15:0] acc_val;
    int          pick;

    // known values on every input from time zero
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = nfa_bm_pkg::OP_WRITE;
    in_state_index = '0;
    in_symbol      = '0;
    in_target_set  = '0;
    cfg_wr_en      = 1'b0;
    cfg_index      = nfa_bm_pkg::CFG_START_MASK;
    cfg_wr_data    = '0;
    err_cnt        = 0;
    pressure_req   = 1'b0;
    snd_idle_pct   = 36;
    rcv_idle_pct   = 74;

    for (int i = 0; i < ROWS; i++) nfa_rows[i] = '0;
    live_set     = '0;
    start_set_q  = nfa_bm_pkg::START_MASK_RST;
    accept_set_q = nfa_bm_pkg::ACCEPT_MASK_RST;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // directed part runs on the reset mask values; the input stays stalled
    // through the clearing pass, the handshake takes care of that
    for (int i = 0; i < N_DIR; i++) begin
      send_item(DIRECTED[i].op, DIRECTED[i].idx, DIRECTED[i].sym, DIRECTED[i].tgt,
                DIRECTED[i].known, {DIRECTED[i].exp_set, DIRECTED[i].exp_match});
    end

    // random phases, masks rewritten between them while the block is idle
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: begin
          st_val  = 16'h0001;
          acc_val = 16'h00F0;
        end
        1: begin
          st_val  = 16'hFFFF;
          acc_val = 16'h0000;
        end
        2: begin
          st_val  = 16'h0000;
          acc_val = 16'hFFFF;
        end
        default: begin
          st_val  = sparse_set() | 16'h0001;
          acc_val = 16'($urandom_range(0, 65535));
        end
      endcase
      write_cfg(nfa_bm_pkg::CFG_START_MASK, st_val);
      write_cfg(nfa_bm_pkg::CFG_ACCEPT_MASK, acc_val);

      // sender/receiver idle mix: 36/74, then 74/36, then none
      case (ph)
        0: begin
          snd_idle_pct = 36;
          rcv_idle_pct = 74;
        end
        1: begin
          snd_idle_pct = 74;
          rcv_idle_pct = 36;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      if (ph == 3) pressure_req = 1'b1;

      for (int n = 0; n < PHASE_LEN; n++) begin
        pick  = $urandom_range(0, 99);
        r_idx = 4'($urandom_range(0, 15));
        r_sym = pick_symbol();
        r_tgt = ($urandom_range(0, 99) < 85) ? sparse_set() : 16'($urandom_range(0, 65535));
        if (pick < 30) r_op = nfa_bm_pkg::OP_WRITE;
        else if (pick < 42) r_op = nfa_bm_pkg::OP_START;
        else if (pick < 95) r_op = nfa_bm_pkg::OP_SYMBOL;
        else r_op = OP_UNUSED;
        // symbol and start transactions carry random junk in unused fields
        send_item(r_op, r_idx, r_sym, r_tgt, 1'b0, '0);
      end
    end

    // let every result come out, then a few more cycles for stray outputs
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (TAIL_LEN) @(negedge clk);
    if (pending_q.size() != 0) flag_error("results still pending at end of run");

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
